FILE: src/braam_pkg.sv
// ----------------------------------------------------------------------------
// braam_pkg
// shared types and constants for the blocked range affine array modulo 10007
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package braam_pkg;

    localparam int VAL_W = 14;
    localparam logic [VAL_W-1:0] MODULUS = 14'd10007;
    // 2^16 mod 10007 and 2^32 mod 10007
    localparam logic [VAL_W-1:0] POW16_MOD = 14'd5494;
    localparam logic [VAL_W-1:0] POW32_MOD = 14'd2924;
    localparam logic [VAL_W-1:0] NEG_FIX = 14'd7083;
    // floor(2^30 / 10007)
    localparam logic [16:0] RECIP = 17'd107299;
    localparam int RECIP_SHIFT = 30;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MUL   = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RED,
        S_RED_FIX,
        S_FIND,
        S_TAG_RD,
        S_BLK,
        S_EL_RD,
        S_EL_P1,
        S_EL_P2,
        S_EL_WR,
        S_TAG_CLR,
        S_TAG_M1,
        S_TAG_M2,
        S_TAG_A,
        S_TAG_WR,
        S_NEXT,
        S_LD_WR,
        S_Q_RD,
        S_Q_CALC,
        S_OUT
    } state_t;

endpackage

FILE: src/blocked_range_affine_mod_array_top.sv
// ----------------------------------------------------------------------------
// blocked_range_affine_mod_array_top
// array of residues modulo 10007 in blocks with lazy multiply and add tags,
// served by one shared three-stage modular multiply-add unit
// work: load and partial-block range work go element by element through each
//   partial block, whole blocks take a tag update each, all through the single
//   shared unit
// throughput: one item at a time, next item taken once the current one ends
// reset: a clearing pass zeroes the elements and resets the tags, during
//   which no item is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blocked_range_affine_mod_array_top #(
    parameter int ARRAY_SIZE = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [9:0]  first_index,
    input  logic [9:0]  last_index,
    input  logic signed [31:0] operand,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [13:0] query_value
);

    localparam int BC = (ARRAY_SIZE + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW = $clog2(ARRAY_SIZE);
    localparam int BW = (BC > 1) ? $clog2(BC) : 1;
    localparam int SW = $clog2(ARRAY_SIZE + BLOCK_SIZE) + 1;
    localparam int VW = braam_pkg::VAL_W;

    braam_pkg::state_t state_reg, state_next;

    // item registers
    logic [1:0]      op_reg;
    logic [9:0]      first_raw_reg, last_raw_reg;
    logic [31:0]     operand_reg;
    logic [VW-1:0]   v_reg;
    logic [SW-1:0]   first_reg, last_reg, target_reg;
    logic [SW-1:0]   start_reg, end_reg, ptr_reg;
    logic [BW-1:0]   b_reg;
    logic [VW-1:0]   mul_t_reg, add_t_reg, e_reg;
    logic            busy_reg;
    logic            result_valid_reg;
    logic [VW-1:0]   query_value_reg;
    logic [VW-1:0]   q_calc_reg;

    // memories
    logic [VW-1:0] elem_mem [ARRAY_SIZE];
    logic [VW-1:0] mul_mem [BC];
    logic [VW-1:0] add_mem [BC];
    logic [VW-1:0] elem_rd, mul_rd, add_rd;
    logic          elem_we, tag_we;
    logic [AW-1:0] elem_wa;
    logic [VW-1:0] elem_wd, mul_wd, add_wd;
    logic [BW-1:0] tag_wa;

    // shared unit
    logic          u_start;
    logic [15:0]   u_a, u_c;
    logic [VW-1:0] u_b;
    logic          u_s1_v, u_s2_v, u_s3_v;
    logic [29:0]   u_p1_reg, u_p2_reg;
    logic [16:0]   u_q_reg;
    logic [VW-1:0] u_res_reg;
    logic [46:0]   u_qprod;
    logic [29:0]   u_rem;
    logic          u_done;

    logic          last_in, first_in;
    logic [SW-1:0] last_clip;
    logic [SW-1:0] blk_end_raw;
    logic [SW-1:0] blk_end;
    logic          whole_blk, in_range, is_mul;
    logic [VW-1:0] red_val;

    assign u_done = u_s3_v;
    assign is_mul = (op_reg == braam_pkg::OP_MUL);
    assign last_in = ({22'd0, last_raw_reg} < ARRAY_SIZE);
    assign first_in = ({22'd0, first_raw_reg} < ARRAY_SIZE);
    assign last_clip = last_in ? SW'(last_raw_reg) : SW'(ARRAY_SIZE - 1);
    assign blk_end_raw = start_reg + SW'(BLOCK_SIZE - 1);
    assign blk_end = (blk_end_raw > SW'(ARRAY_SIZE - 1)) ? SW'(ARRAY_SIZE - 1) : blk_end_raw;
    assign whole_blk = (start_reg >= first_reg) && (blk_end <= last_reg);
    assign in_range = (op_reg != braam_pkg::OP_LOAD) && (ptr_reg >= first_reg)
                      && (ptr_reg <= last_reg);
    assign red_val = !operand_reg[31] ? u_res_reg :
                     (u_res_reg >= braam_pkg::POW32_MOD) ?
                     (u_res_reg - braam_pkg::POW32_MOD) : (u_res_reg + braam_pkg::NEG_FIX);

    // modular multiply-add: (a*b + c) mod 10007
    assign u_qprod = 47'(u_p1_reg) * 47'(braam_pkg::RECIP);
    assign u_rem = u_p2_reg - 30'(u_q_reg) * 30'(braam_pkg::MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_s1_v <= 1'b0;
            u_s2_v <= 1'b0;
            u_s3_v <= 1'b0;
        end
        else
        begin
            u_s1_v <= u_start;
            u_s2_v <= u_s1_v;
            u_s3_v <= u_s2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        u_p1_reg <= 30'(u_a) * 30'(u_b) + 30'(u_c);
        u_p2_reg <= u_p1_reg;
        u_q_reg <= u_qprod[46:braam_pkg::RECIP_SHIFT];
        u_res_reg <= (u_rem >= 30'(braam_pkg::MODULUS)) ?
                     VW'(u_rem - 30'(braam_pkg::MODULUS)) : VW'(u_rem);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_wa] <= elem_wd;
        end
        elem_rd <= elem_mem[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            mul_mem[tag_wa] <= mul_wd;
            add_mem[tag_wa] <= add_wd;
        end
        mul_rd <= mul_mem[b_reg];
        add_rd <= add_mem[b_reg];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            braam_pkg::S_CLEAR:
                if (ptr_reg == SW'(ARRAY_SIZE - 1)) state_next = braam_pkg::S_IDLE;
            braam_pkg::S_IDLE:
                if (item_valid) state_next = braam_pkg::S_RED;
            braam_pkg::S_RED:
                if (u_done) state_next = braam_pkg::S_RED_FIX;
            braam_pkg::S_RED_FIX:
            begin
                unique case (op_reg)
                    braam_pkg::OP_LOAD:
                        state_next = last_in ? braam_pkg::S_FIND : braam_pkg::S_IDLE;
                    braam_pkg::OP_QUERY:
                        state_next = last_in ? braam_pkg::S_FIND : braam_pkg::S_OUT;
                    default:
                        state_next = (first_in && first_raw_reg <= last_raw_reg) ?
                                     braam_pkg::S_FIND : braam_pkg::S_IDLE;
                endcase
            end
            braam_pkg::S_FIND:
                if (start_reg + SW'(BLOCK_SIZE) > target_reg) state_next = braam_pkg::S_TAG_RD;
            braam_pkg::S_TAG_RD:
                state_next = braam_pkg::S_BLK;
            braam_pkg::S_BLK:
            begin
                if (op_reg == braam_pkg::OP_QUERY)
                    state_next = braam_pkg::S_Q_RD;
                else if (op_reg == braam_pkg::OP_LOAD || !whole_blk)
                    state_next = braam_pkg::S_EL_RD;
                else if (is_mul)
                    state_next = braam_pkg::S_TAG_M1;
                else
                    state_next = braam_pkg::S_TAG_A;
            end
            braam_pkg::S_EL_RD:
                state_next = braam_pkg::S_EL_P1;
            braam_pkg::S_EL_P1:
                if (u_done) state_next = in_range ? braam_pkg::S_EL_P2 : braam_pkg::S_EL_WR;
            braam_pkg::S_EL_P2:
                if (u_done) state_next = braam_pkg::S_EL_WR;
            braam_pkg::S_EL_WR:
                state_next = (ptr_reg == end_reg) ? braam_pkg::S_TAG_CLR : braam_pkg::S_EL_RD;
            braam_pkg::S_TAG_CLR:
                state_next = (op_reg == braam_pkg::OP_LOAD) ? braam_pkg::S_LD_WR :
                             braam_pkg::S_NEXT;
            braam_pkg::S_TAG_M1:
                if (u_done) state_next = braam_pkg::S_TAG_M2;
            braam_pkg::S_TAG_M2:
                if (u_done) state_next = braam_pkg::S_TAG_WR;
            braam_pkg::S_TAG_A:
                if (u_done) state_next = braam_pkg::S_TAG_WR;
            braam_pkg::S_TAG_WR:
                state_next = braam_pkg::S_NEXT;
            braam_pkg::S_NEXT:
                state_next = (end_reg >= last_reg) ? braam_pkg::S_IDLE : braam_pkg::S_TAG_RD;
            braam_pkg::S_LD_WR:
                state_next = braam_pkg::S_IDLE;
            braam_pkg::S_Q_RD:
                state_next = braam_pkg::S_Q_CALC;
            braam_pkg::S_Q_CALC:
                if (u_done) state_next = braam_pkg::S_OUT;
            braam_pkg::S_OUT:
                if (!result_valid_reg || result_ready) state_next = braam_pkg::S_IDLE;
            default:
                state_next = braam_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        item_ready = 1'b0;
        u_start = 1'b0;
        u_a = 16'd0;
        u_b = 14'd0;
        u_c = 16'd0;
        elem_we = 1'b0;
        elem_wa = ptr_reg[AW-1:0];
        elem_wd = e_reg;
        tag_we = 1'b0;
        tag_wa = b_reg;
        mul_wd = mul_t_reg;
        add_wd = add_t_reg;
        unique case (state_reg)
            braam_pkg::S_CLEAR:
            begin
                elem_we = 1'b1;
                elem_wd = '0;
                tag_we = (ptr_reg < SW'(BC));
                tag_wa = BW'(ptr_reg);
                mul_wd = 14'd1;
                add_wd = '0;
            end
            braam_pkg::S_IDLE:
                item_ready = 1'b1;
            braam_pkg::S_RED:
            begin
                u_start = !busy_reg;
                u_a = operand_reg[31:16];
                u_b = braam_pkg::POW16_MOD;
                u_c = operand_reg[15:0];
            end
            braam_pkg::S_EL_P1:
            begin
                u_start = !busy_reg;
                u_a = 16'(elem_rd);
                u_b = mul_t_reg;
                u_c = 16'(add_t_reg);
            end
            braam_pkg::S_EL_P2:
            begin
                u_start = !busy_reg;
                u_a = 16'(e_reg);
                u_b = is_mul ? v_reg : 14'd1;
                u_c = is_mul ? 16'd0 : 16'(v_reg);
            end
            braam_pkg::S_EL_WR:
                elem_we = 1'b1;
            braam_pkg::S_TAG_CLR:
            begin
                tag_we = 1'b1;
                mul_wd = 14'd1;
                add_wd = '0;
            end
            braam_pkg::S_TAG_M1:
            begin
                u_start = !busy_reg;
                u_a = 16'(mul_t_reg);
                u_b = v_reg;
            end
            braam_pkg::S_TAG_M2:
            begin
                u_start = !busy_reg;
                u_a = 16'(add_t_reg);
                u_b = v_reg;
            end
            braam_pkg::S_TAG_A:
            begin
                u_start = !busy_reg;
                u_a = 16'(add_t_reg);
                u_b = 14'd1;
                u_c = 16'(v_reg);
            end
            braam_pkg::S_TAG_WR:
                tag_we = 1'b1;
            braam_pkg::S_LD_WR:
            begin
                elem_we = 1'b1;
                elem_wa = target_reg[AW-1:0];
                elem_wd = v_reg;
            end
            braam_pkg::S_Q_CALC:
            begin
                u_start = !busy_reg;
                u_a = 16'(elem_rd);
                u_b = mul_t_reg;
                u_c = 16'(add_t_reg);
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= braam_pkg::S_CLEAR;
            busy_reg <= 1'b0;
            ptr_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (u_start)
                busy_reg <= 1'b1;
            else if (u_done)
                busy_reg <= 1'b0;
            if (state_reg == braam_pkg::S_CLEAR)
                ptr_reg <= ptr_reg + 1'b1;
            else if (state_reg == braam_pkg::S_BLK)
                ptr_reg <= (op_reg == braam_pkg::OP_QUERY) ? target_reg : start_reg;
            else if (state_reg == braam_pkg::S_EL_WR && ptr_reg != end_reg)
                ptr_reg <= ptr_reg + 1'b1;
            if (state_reg == braam_pkg::S_OUT && state_next == braam_pkg::S_IDLE)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            braam_pkg::S_IDLE:
            begin
                op_reg <= opcode;
                first_raw_reg <= first_index;
                last_raw_reg <= last_index;
                operand_reg <= operand;
            end
            braam_pkg::S_RED_FIX:
            begin
                v_reg <= red_val;
                first_reg <= SW'(first_raw_reg);
                last_reg <= last_clip;
                target_reg <= (op_reg == braam_pkg::OP_MUL || op_reg == braam_pkg::OP_ADD) ?
                              SW'(first_raw_reg) : SW'(last_raw_reg);
                start_reg <= '0;
                b_reg <= '0;
                q_calc_reg <= '0;
            end
            braam_pkg::S_FIND:
            begin
                if (start_reg + SW'(BLOCK_SIZE) <= target_reg)
                begin
                    start_reg <= start_reg + SW'(BLOCK_SIZE);
                    b_reg <= b_reg + 1'b1;
                end
            end
            braam_pkg::S_BLK:
            begin
                mul_t_reg <= mul_rd;
                add_t_reg <= add_rd;
                end_reg <= blk_end;
            end
            braam_pkg::S_EL_P1, braam_pkg::S_EL_P2:
                if (u_done) e_reg <= u_res_reg;
            braam_pkg::S_TAG_M1:
                if (u_done) mul_t_reg <= u_res_reg;
            braam_pkg::S_TAG_M2, braam_pkg::S_TAG_A:
                if (u_done) add_t_reg <= u_res_reg;
            braam_pkg::S_NEXT:
            begin
                start_reg <= start_reg + SW'(BLOCK_SIZE);
                b_reg <= b_reg + 1'b1;
            end
            braam_pkg::S_Q_CALC:
                if (u_done) q_calc_reg <= u_res_reg;
            braam_pkg::S_OUT:
                if (state_next == braam_pkg::S_IDLE) query_value_reg <= q_calc_reg;
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign query_value = query_value_reg;

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (query_value < braam_pkg::MODULUS))
        else $error("result not reduced");

    a_unit_single: assert property (@(posedge clk) disable iff (!rst_n)
        u_s1_v |-> (!u_s2_v && !u_s3_v))
        else $error("shared unit overlapped");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == braam_pkg::S_CLEAR) |-> (!result_valid && !item_ready))
        else $error("activity during clearing pass");

endmodule

FILE: test/tb_blocked_range_affine_mod_array_top.sv
// ----------------------------------------------------------------------------
// tb_blocked_range_affine_mod_array_top
// drives loads, range multiplies, range adds and point queries through the
// blocked residue array, predicts every query value with a lazy-tag model of
// its own and checks each result transfer against it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_blocked_range_affine_mod_array_top;

    localparam int N_EL = 1024;
    localparam int BSZ = 32;
    localparam int NBLK = N_EL / BSZ;
    localparam int MODV = 10007;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        braam_pkg::opcode_t op;
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [31:0] arg;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  opcode;
    logic [9:0]  first_index;
    logic [9:0]  last_index;
    logic signed [31:0] operand;
    logic        result_valid;
    logic        result_ready;
    logic [13:0] query_value;

    blocked_range_affine_mod_array_top u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .opcode(opcode), .first_index(first_index), .last_index(last_index),
        .operand(operand),
        .result_valid(result_valid), .result_ready(result_ready),
        .query_value(query_value)
    );

    cmd_t        pending_cmds[$];
    logic [13:0] expected_values[$];
    int          cells[N_EL];
    int          mul_tags[NBLK];
    int          add_tags[NBLK];
    int          errors = 0;
    int          cycles = 0;
    int          n_sent = 0;
    int          n_queries = 0;
    int          gap_in = 0;
    int          gap_out = 0;
    bit          stim_done = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int residue(logic [31:0] raw);
        longint s;
        s = longint'($signed(raw)) % MODV;
        if (s < 0) s += MODV;
        return int'(s);
    endfunction

    function automatic void flush_block(int b);
        for (int i = b * BSZ; i < (b + 1) * BSZ; i++)
            cells[i] = (cells[i] * mul_tags[b] + add_tags[b]) % MODV;
        mul_tags[b] = 1;
        add_tags[b] = 0;
    endfunction

    function automatic void apply_cmd(cmd_t c);
        int v, lo, hi, s, e;
        v = residue(c.arg);
        lo = c.lo;
        hi = c.hi;
        case (c.op) inside
            braam_pkg::OP_LOAD:
            begin
                flush_block(hi / BSZ);
                cells[hi] = v;
            end
            braam_pkg::OP_MUL, braam_pkg::OP_ADD:
            begin
                if (lo <= hi)
                begin
                    for (int b = lo / BSZ; b <= hi / BSZ; b++)
                    begin
                        s = b * BSZ;
                        e = s + BSZ - 1;
                        if (s >= lo && e <= hi)
                        begin
                            if (c.op == braam_pkg::OP_MUL)
                            begin
                                mul_tags[b] = mul_tags[b] * v % MODV;
                                add_tags[b] = add_tags[b] * v % MODV;
                            end
                            else
                                add_tags[b] = (add_tags[b] + v) % MODV;
                        end
                        else
                        begin
                            flush_block(b);
                            for (int i = (s > lo ? s : lo); i <= (e < hi ? e : hi); i++)
                                cells[i] = (c.op == braam_pkg::OP_MUL) ? cells[i] * v % MODV
                                                                       : (cells[i] + v) % MODV;
                        end
                    end
                end
            end
            default:
            begin
                expected_values.push_back(14'((cells[hi] * mul_tags[hi / BSZ]
                                               + add_tags[hi / BSZ]) % MODV));
                n_queries++;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 3);
            3: return 32'hffff_ffff - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_cmd(braam_pkg::opcode_t op, int lo, int hi, logic [31:0] arg);
        cmd_t c;
        c.op = op;
        c.lo = 10'(lo);
        c.hi = 10'(hi);
        c.arg = arg;
        pending_cmds.push_back(c);
    endfunction

    initial
    begin
        int a, b, w;
        for (int i = 0; i < N_EL; i++) cells[i] = 0;
        for (int i = 0; i < NBLK; i++)
        begin
            mul_tags[i] = 1;
            add_tags[i] = 0;
        end
        push_cmd(braam_pkg::OP_QUERY, 0, 0, 0);
        push_cmd(braam_pkg::OP_QUERY, 0, 1023, 0);
        push_cmd(braam_pkg::OP_LOAD, 0, 0, 32'h7fff_ffff);
        push_cmd(braam_pkg::OP_LOAD, 0, 1023, 32'h8000_0000);
        push_cmd(braam_pkg::OP_LOAD, 0, 5, 32'hffff_ffff);
        push_cmd(braam_pkg::OP_LOAD, 0, 6, 10007);
        push_cmd(braam_pkg::OP_ADD, 0, 1023, 32'hffff_fffe);
        push_cmd(braam_pkg::OP_MUL, 0, 1023, 32'h8000_0000);
        push_cmd(braam_pkg::OP_ADD, 3, 40, 12345);
        push_cmd(braam_pkg::OP_MUL, 31, 64, 32'hffff_ffff);
        push_cmd(braam_pkg::OP_ADD, 64, 95, 7);
        push_cmd(braam_pkg::OP_MUL, 100, 50, 3);
        push_cmd(braam_pkg::OP_ADD, 1023, 0, 3);
        push_cmd(braam_pkg::OP_ADD, 1023, 1023, 32'h7fff_ffff);
        push_cmd(braam_pkg::OP_LOAD, 1023, 35, 99);
        push_cmd(braam_pkg::OP_QUERY, 0, 5, 0);
        push_cmd(braam_pkg::OP_QUERY, 0, 35, 0);
        push_cmd(braam_pkg::OP_QUERY, 1023, 64, 32'hffff_ffff);
        push_cmd(braam_pkg::OP_QUERY, 0, 1023, 0);
        push_cmd(braam_pkg::OP_QUERY, 0, 40, 0);
        for (int k = 0; k < 1000; k++)
        begin
            w = $urandom_range(0, 9);
            if (w < 2)
            begin
                a = $urandom_range(0, 1023);
                b = a + $urandom_range(0, 70);
                if (b > 1023) b = 1023;
            end
            else if (w < 3)
            begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            else
            begin
                a = $urandom_range(0, 1023);
                b = a + $urandom_range(0, 3);
                if (b > 1023) b = 1023;
            end
            case ($urandom_range(0, 9))
                0, 1: push_cmd(braam_pkg::OP_LOAD, $urandom_range(0, 1023), b, pick_arg());
                2, 3: push_cmd(braam_pkg::OP_MUL, a, b, pick_arg());
                4, 5: push_cmd(braam_pkg::OP_ADD, a, b, pick_arg());
                default: push_cmd(braam_pkg::OP_QUERY, $urandom_range(0, 1023), b, pick_arg());
            endcase
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            opcode      <= 2'd0;
            first_index <= 10'd0;
            last_index  <= 10'd0;
            operand     <= 32'd0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
            begin
                apply_cmd(pending_cmds.pop_front());
                n_sent++;
            end
            if (gap_in > 0 || pending_cmds.size() == 0)
            begin
                item_valid <= 1'b0;
                if (gap_in > 0) gap_in <= gap_in - 1;
                if (pending_cmds.size() == 0) stim_done <= 1'b1;
            end
            else
            begin
                item_valid  <= 1'b1;
                opcode      <= pending_cmds[0].op;
                first_index <= pending_cmds[0].lo;
                last_index  <= pending_cmds[0].hi;
                operand     <= pending_cmds[0].arg;
                gap_in      <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %0d",
                             $time, query_value);
                    errors++;
                end
                else if (query_value !== expected_values[0])
                begin
                    $display("%0t: query_value mismatch, expected %0d, actual %0d",
                             $time, expected_values[0], query_value);
                    errors++;
                    void'(expected_values.pop_front());
                end
                else
                    void'(expected_values.pop_front());
            end
            if (gap_out > 0)
            begin
                result_ready <= 1'b0;
                gap_out <= gap_out - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                gap_out <= pick_gap();
            end
        end
    end

    initial
    begin
        wait (stim_done && expected_values.size() == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d items, %0d of them point queries, with idle gaps on both sides",
                 n_sent, n_queries);
        if (errors == 0 && expected_values.size() == 0)
            $display("tb_blocked_range_affine_mod_array_top: clean");
        else
            $display("tb_blocked_range_affine_mod_array_top: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_blocked_range_affine_mod_array_top: errors");
            $finish;
        end
    end

endmodule

FILE: filelist.f
src/braam_pkg.sv
src/blocked_range_affine_mod_array_top.sv
test/tb_blocked_range_affine_mod_array_top.sv
